// ----- rtl/dsg_pkg.sv -----
// Shared types, constants and the quarter-wave table builder for the delayed sine generator.
// No dependencies; used by dsg_ctrl, dsg_datapath and delayed_sine_generator.
`default_nettype none

package dsg_pkg;

    // Default sizes
    localparam int QUARTER_TABLE_BITS_DEF = 8;
    localparam int TIME_BITS_DEF          = 32;

    // Register widths and reset values
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int ROM_W       = 15;
    localparam int PHASE_W     = 32;

    localparam logic [31:0] PHASE_RATE_RST = 32'd4295;
    localparam logic [31:0] START_DELAY_RST = 32'd0;
    localparam logic [15:0] AMPLITUDE_RST   = 16'd0;

    // pi/2 in unsigned Q60
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_RATE  = 2'd0,
        REG_START_DELAY = 2'd1,
        REG_AMPLITUDE   = 2'd2
    } reg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MUL,
        S_ROM,
        S_PROD,
        S_OUT
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;
        logic do_cmp;
        logic do_mul;
        logic do_rom;
        logic do_prod;
        logic load_out;
    } dsg_cmd_t;

    // Product of two unsigned Q60 values below 2^62, in Q60
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] r;
        ah = a >> 32;
        al = a & 64'h00000000FFFFFFFF;
        bh = b >> 32;
        bl = b & 64'h00000000FFFFFFFF;
        r  = (ah * bh) << 4;
        r  = r + ((ah * bl) >> 28);
        r  = r + ((al * bh) >> 28);
        r  = r + ((al * bl) >> 60);
        return r;
    endfunction

    // Divide a Taylor term by (2k)(2k+1)
    function automatic logic [63:0] term_div(input logic [63:0] t, input int k);
        logic [63:0] q;
        case (k)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            8:       q = t / 64'd272;
            9:       q = t / 64'd342;
            10:      q = t / 64'd420;
            11:      q = t / 64'd506;
            12:      q = t / 64'd600;
            13:      q = t / 64'd702;
            default: q = t;
        endcase
        return q;
    endfunction

    // round(32767*sin(pi/2*i/2^qbits)), evaluated at elaboration
    function automatic logic [ROM_W-1:0] quarter_entry(input int i, input int qbits);
        logic [63:0] step;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        step = HALF_PI_Q60 >> qbits;
        frac = HALF_PI_Q60 & ((64'd1 << qbits) - 64'd1);
        x    = step * 64'(i) + ((frac * 64'(i)) >> qbits);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 13; k++) begin
            term = term_div(mul_q60(term, x2), k);
            if ((k % 2) == 1) begin
                sum = sum - term;
            end
            else begin
                sum = sum + term;
            end
        end
        res = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
        if (i == 0) begin
            res = 64'd0;
        end
        return res[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dsg_ctrl.sv -----
// Sequencer for the delayed sine generator: input/output handshakes and datapath commands.
// Depends on dsg_pkg.
`default_nettype none

module dsg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dsg_pkg::dsg_cmd_t      cmd
);

    dsg_pkg::state_t state_reg;
    dsg_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsg_pkg::S_IDLE:
            begin
                if (in_valid) begin
                    state_next = dsg_pkg::S_CMP;
                end
            end
            dsg_pkg::S_CMP:  state_next = dsg_pkg::S_MUL;
            dsg_pkg::S_MUL:  state_next = dsg_pkg::S_ROM;
            dsg_pkg::S_ROM:  state_next = dsg_pkg::S_PROD;
            dsg_pkg::S_PROD: state_next = dsg_pkg::S_OUT;
            dsg_pkg::S_OUT:
            begin
                if (out_free) begin
                    state_next = dsg_pkg::S_IDLE;
                end
            end
            default:         state_next = dsg_pkg::S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            dsg_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            dsg_pkg::S_CMP:  cmd.do_cmp  = 1'b1;
            dsg_pkg::S_MUL:  cmd.do_mul  = 1'b1;
            dsg_pkg::S_ROM:  cmd.do_rom  = 1'b1;
            dsg_pkg::S_PROD: cmd.do_prod = 1'b1;
            dsg_pkg::S_OUT:  cmd.load_out = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Set valid on load, drop it on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= dsg_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dsg_datapath.sv -----
// Datapath of the delayed sine generator: config registers, elapsed time, phase multiply,
// quarter-wave table and amplitude scaling. Depends on dsg_pkg.
`default_nettype none

module dsg_datapath #(
    parameter int QUARTER_TABLE_BITS = dsg_pkg::QUARTER_TABLE_BITS_DEF,
    parameter int TIME_BITS          = dsg_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dsg_pkg::dsg_cmd_t                  cmd,
    input  wire logic                               cfg_wr_en,
    input  wire logic [dsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [dsg_pkg::STEP_W-1:0]         time_step_us,
    output logic signed [dsg_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    started
);

    localparam int QN   = 1 << QUARTER_TABLE_BITS;
    localparam int AW   = QUARTER_TABLE_BITS + 1;
    localparam int CW   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int PW   = dsg_pkg::PHASE_W;
    localparam int RW   = dsg_pkg::ROM_W;
    localparam int SW   = dsg_pkg::SAMPLE_W;

    // Configuration and elapsed time
    logic [31:0]          phase_rate_reg;
    logic [31:0]          start_delay_reg;
    logic signed [15:0]   amplitude_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [TIME_BITS-1:0] elapsed_next;
    logic [TIME_BITS:0]   elapsed_sum;

    // Per-item pipeline registers
    logic [PW-1:0]        since_reg;
    logic                 started_reg;
    logic [PW-1:0]        phase_reg;
    logic [RW-1:0]        rom_reg;
    logic                 neg_reg;
    logic signed [31:0]   prod_reg;
    logic signed [SW-1:0] sample_reg;
    logic                 started_out_reg;

    logic [CW-1:0]        elapsed_ext;
    logic [CW-1:0]        delay_ext;
    logic [CW-1:0]        since_full;
    logic [PW-1:0]        phase_prod;
    logic [QUARTER_TABLE_BITS-1:0] tbl_idx;
    logic [AW-1:0]        rom_addr;
    logic signed [15:0]   rom_signed;
    logic signed [31:0]   prod_full;
    logic [RW-1:0]        rom_w [0:QN];

    // Constant quarter-wave table
    for (genvar g = 0; g <= QN; g++) begin : g_rom
        assign rom_w[g] = dsg_pkg::quarter_entry(g, QUARTER_TABLE_BITS);
    end

    // Saturating elapsed-time add
    assign elapsed_sum = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(time_step_us);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (cfg_wr_en && (cfg_index == dsg_pkg::REG_PHASE_RATE ||
                          cfg_index == dsg_pkg::REG_START_DELAY ||
                          cfg_index == dsg_pkg::REG_AMPLITUDE)) begin
            elapsed_next = '0;
        end
        else if (cmd.load_in) begin
            elapsed_next = elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];
        end
    end

    // Hold configuration and elapsed time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_rate_reg  <= dsg_pkg::PHASE_RATE_RST;
            start_delay_reg <= dsg_pkg::START_DELAY_RST;
            amplitude_reg   <= dsg_pkg::AMPLITUDE_RST;
            elapsed_reg     <= '0;
        end
        else begin
            elapsed_reg <= elapsed_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    dsg_pkg::REG_PHASE_RATE:  phase_rate_reg  <= cfg_data;
                    dsg_pkg::REG_START_DELAY: start_delay_reg <= cfg_data;
                    dsg_pkg::REG_AMPLITUDE:   amplitude_reg   <= cfg_data[15:0];
                    default:                  phase_rate_reg  <= phase_rate_reg;
                endcase
            end
        end
    end

    // Delay compare and time since start
    assign elapsed_ext = CW'(elapsed_reg);
    assign delay_ext   = CW'(start_delay_reg);
    assign since_full  = elapsed_ext - delay_ext;

    // Phase = since * rate, low 32 bits
    assign phase_prod = since_reg * phase_rate_reg;

    // Quadrant mirror for the table address
    assign tbl_idx  = phase_reg[PW-3 -: QUARTER_TABLE_BITS];
    assign rom_addr = phase_reg[PW-2] ? (AW'(QN) - {1'b0, tbl_idx}) : {1'b0, tbl_idx};

    // Sign by quadrant, then scale by amplitude
    assign rom_signed = neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
    assign prod_full  = rom_signed * amplitude_reg;

    // Advance the per-item stages
    always_ff @(posedge clk)
    begin
        if (cmd.do_cmp) begin
            started_reg <= (elapsed_ext >= delay_ext);
            since_reg   <= since_full[PW-1:0];
        end
        if (cmd.do_mul) begin
            phase_reg <= phase_prod;
        end
        if (cmd.do_rom) begin
            rom_reg <= rom_w[rom_addr];
            neg_reg <= phase_reg[PW-1];
        end
        if (cmd.do_prod) begin
            prod_reg <= prod_full;
        end
        if (cmd.load_out) begin
            sample_reg      <= started_reg ? prod_reg[30:15] : '0;
            started_out_reg <= started_reg;
        end
    end

    assign sample  = sample_reg;
    assign started = started_out_reg;

endmodule

`default_nettype wire

// ----- rtl/delayed_sine_generator.sv -----
// Top level of the delayed sine generator: joins the sequencer and the datapath.
// Depends on dsg_pkg, dsg_ctrl and dsg_datapath.
//
//  Channel  | Signals                          | Direction | Transfer
//  ---------+----------------------------------+-----------+---------------------------
//  in       | in_valid, in_ready, time_step_us | input     | in_valid && in_ready
//  out      | out_valid, out_ready, sample,    | output    | out_valid && out_ready
//           | started                          |           |
//  cfg      | cfg_wr_en, cfg_index, cfg_data   | input     | cfg_wr_en (no wait)
//
// After the input transfer, each item passes in order through delay compare, phase multiply,
// table read, amplitude multiply and output load. The sequencer walks one item at a time
// through these steps, so the next item is taken only after the previous one is loaded.
// A result waiting in the output register does not block the next input; a stalled output
// holds the sequencer in its last step. Reset clears control state and elapsed time and
// returns the config registers to their defaults.
`default_nettype none

module delayed_sine_generator #(
    parameter int QUARTER_TABLE_BITS = dsg_pkg::QUARTER_TABLE_BITS_DEF,
    parameter int TIME_BITS          = dsg_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [dsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [dsg_pkg::STEP_W-1:0]         time_step_us,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [dsg_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    started
);

    dsg_pkg::dsg_cmd_t cmd;

    dsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dsg_datapath #(
        .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS),
        .TIME_BITS          (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .time_step_us (time_step_us),
        .sample       (sample),
        .started      (started)
    );

endmodule

`default_nettype wire

// ----- tb/delayed_sine_generator_test.sv -----
// Testbench for the delayed sine generator: directed ticks, a long maximum-step sweep, random
// phases. A small scoreboard class predicts each sample and started flag from the time steps.
// Depends on dsg_pkg and the delayed_sine_generator RTL.
`default_nettype none

module delayed_sine_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsg_pkg::*;

    // Index past the end of the register list: a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 90;
    localparam int SWEEP_ITEMS    = 40;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       started;
    } sine_result_t;

    // Tracks elapsed time and registers, holds the samples still owed by the block
    class sine_tracker;
        localparam int TABLE_BITS   = QUARTER_TABLE_BITS_DEF;
        localparam int QUARTER_SIZE = 1 << TABLE_BITS;
        localparam int MAX_REPORTS  = 40;

        logic [31:0]          phase_rate;
        logic [31:0]          start_delay;
        logic signed [15:0]   amplitude;
        logic [31:0]          elapsed_us;
        int                   quarter_wave [0:QUARTER_SIZE];
        sine_result_t         owed_samples [$];
        int                   errors;
        int                   reports;

        function void reset_state();
            real angle;
            // Build the quarter-wave table from the sine itself
            for (int i = 0; i <= QUARTER_SIZE; i++)
            begin
                angle = 1.5707963267948966 * real'(i) / real'(QUARTER_SIZE);
                quarter_wave[i] = $rtoi(32767.0 * $sin(angle) + 0.5);
            end
            phase_rate  = PHASE_RATE_RST;
            start_delay = START_DELAY_RST;
            amplitude   = AMPLITUDE_RST;
            elapsed_us  = '0;
            owed_samples.delete();
            errors  = 0;
            reports = 0;
        endfunction

        function void apply_register(logic [CFG_INDEX_W-1:0] index_w,
                                     logic [CFG_DATA_W-1:0] data);
            case (index_w)
                REG_PHASE_RATE:  phase_rate  = data;
                REG_START_DELAY: start_delay = data;
                REG_AMPLITUDE:   amplitude   = data[15:0];
                default:         return;
            endcase
            // Any real register write restarts the elapsed time
            elapsed_us = '0;
        endfunction

        function void note_step(logic [STEP_W-1:0] step_us);
            logic [32:0]           total;
            logic [31:0]           since;
            logic [31:0]           phase;
            logic [1:0]            quad;
            logic [TABLE_BITS-1:0] idx;
            int                    mag;
            int                    prod;
            sine_result_t          want;
            // Advance elapsed time, saturating at all ones
            total = {1'b0, elapsed_us} + 33'(step_us);
            elapsed_us = total[32] ? '1 : total[31:0];
            if (elapsed_us < start_delay)
            begin
                want.sample  = '0;
                want.started = 1'b0;
            end
            else
            begin
                since = elapsed_us - start_delay;
                phase = since * phase_rate;
                quad  = phase[31:30];
                idx   = phase[29 -: TABLE_BITS];
                // Mirror in odd quadrants, negate in the second half turn
                mag = quad[0] ? quarter_wave[QUARTER_SIZE - int'(idx)] : quarter_wave[idx];
                if (quad[1])
                begin
                    mag = -mag;
                end
                prod = mag * int'(amplitude);
                want.sample  = 16'(prod >>> 15);
                want.started = 1'b1;
            end
            owed_samples.push_back(want);
        endfunction

        function void report(string what, int want_v, int got_v);
            errors++;
            if (reports < MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            end
            reports++;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] got_sample, logic got_started);
            sine_result_t want;
            if (owed_samples.size() == 0)
            begin
                report("unexpected transfer (no sample owed)", 0, got_sample);
                return;
            end
            want = owed_samples.pop_front();
            if (got_sample !== want.sample)
            begin
                report("sample", want.sample, got_sample);
            end
            if (got_started !== want.started)
            begin
                report("started", want.started, got_started);
            end
        endfunction

        function int outstanding();
            return owed_samples.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [STEP_W-1:0]          time_step_us;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       started;

    bit          steady;
    bit          hold_request;
    sine_tracker tracker;

    delayed_sine_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .time_step_us (time_step_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .started      (started)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one tick and hold it until the transfer
    task automatic offer_step(input logic [STEP_W-1:0] step_us);
        in_valid     <= 1'b1;
        time_step_us <= step_us;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.note_step(step_us);
    endtask

    // Drop valid now and then, unless in steady mode
    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Hold the input until every owed sample has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write one register while the block is idle
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index_w,
                                  input logic [CFG_DATA_W-1:0] data);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index_w;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.apply_register(index_w, data);
    endtask

    // Output side: random stalls, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                tracker.check_result(sample, started);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        logic [STEP_W-1:0]     step_us;
        reg_index_t            which;
        int                    first;

        tracker = new;
        tracker.reset_state();
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        time_step_us <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero amplitude, no delay
        offer_step(16'h0000);
        offer_step(16'hFFFF);
        offer_step(16'h0001);

        // Full amplitude, a quarter turn every 64 us: walk all quadrants
        write_register(REG_AMPLITUDE, 32'h0000_7FFF);
        write_register(REG_PHASE_RATE, 32'h0100_0000);
        offer_step(16'd0);
        offer_step(16'd16);
        offer_step(16'd48);
        offer_step(16'd64);
        offer_step(16'd64);
        offer_step(16'd64);
        offer_step(16'd32);

        // Start delay: before, exactly at, and after it
        write_register(REG_START_DELAY, 32'd100);
        offer_step(16'd50);
        offer_step(16'd49);
        offer_step(16'd1);
        offer_step(16'd10);

        // Most negative amplitude with junk in the upper bits, maximum rate
        write_register(REG_AMPLITUDE, 32'hABCD_8000);
        write_register(REG_PHASE_RATE, 32'hFFFF_FFFF);
        write_register(REG_START_DELAY, 32'd0);
        offer_step(16'd1);
        offer_step(16'd3);
        offer_step(16'hFFFF);

        // A write past the register list keeps the elapsed time running
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        offer_step(16'd7);
        offer_step(16'd9);

        // Zero rate holds the phase at zero
        write_register(REG_PHASE_RATE, 32'd0);
        offer_step(16'd100);
        offer_step(16'd200);

        // Maximum steps back to back; the delay ends exactly on the twentieth tick
        write_register(REG_PHASE_RATE, 32'h0001_2345);
        write_register(REG_START_DELAY, 32'd1_310_700);
        write_register(REG_AMPLITUDE, 32'd20000);
        steady = 1'b1;
        repeat (SWEEP_ITEMS) offer_step(16'hFFFF);

        // Random phases, each with fresh settings
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            steady = (ph == 0);
            first  = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                which = reg_index_t'((first + k) % 3);
                case (which)
                    REG_PHASE_RATE:
                        case ($urandom_range(0, 4))
                            0:       data = 32'd0;
                            1:       data = 32'hFFFF_FFFF;
                            2:       data = $urandom;
                            3:       data = $urandom_range(1, 1 << 20);
                            default: data = 32'd1 << $urandom_range(16, 31);
                        endcase
                    REG_START_DELAY:
                        case ($urandom_range(0, 3))
                            0:       data = 32'd0;
                            1:       data = 32'hFFFF_FFFF;
                            default: data = $urandom_range(0, 2_000_000);
                        endcase
                    default:
                    begin
                        data = $urandom;
                        case ($urandom_range(0, 4))
                            0:       data[15:0] = 16'h7FFF;
                            1:       data[15:0] = 16'h8000;
                            2:       data[15:0] = 16'h0000;
                            default: data[15:0] = $urandom_range(0, 65535);
                        endcase
                    end
                endcase
                write_register(which, data);
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       step_us = 16'h0000;
                    1:       step_us = 16'hFFFF;
                    2, 3, 4: step_us = $urandom_range(0, 255);
                    5, 6:    step_us = $urandom_range(0, 4095);
                    default: step_us = $urandom_range(0, 65535);
                endcase
                offer_step(step_us);
                maybe_idle();
                // Long output stall while ticks keep coming
                if (ph == 3 && n == 10)
                begin
                    hold_request = 1'b1;
                end
                // Pause the input until the block is empty
                if (ph == 5 && n == 47)
                begin
                    drain();
                end
                if (ph % 2 == 1 && n == 40)
                begin
                    write_register(REG_UNUSED, $urandom);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
